@@ hdl/mprm_pkg.sv @@
// ----------------------------------------------------------------------------
// mprm_pkg
// Shared types, codes and the reply pattern table of the response matcher.
// ----------------------------------------------------------------------------
package mprm_pkg;

  localparam int LINE_DEPTH  = 512;
  localparam int LINE_W      = 10;
  localparam int PAT_COUNT   = 13;
  localparam int PAT_CHARS   = 18;
  localparam int PAT_BITS    = 8 * PAT_CHARS;
  localparam int POS_W       = 5;
  localparam int MATCH_W     = 4;
  localparam int MASK_W      = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_BYTE    = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_RSVD    = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_RUNNING = 3'd0,
    ST_MATCHED = 3'd1,
    ST_ENDED   = 3'd2,
    ST_LIMIT   = 3'd3,
    ST_IDLE    = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEPT_MASK  = 1'b0,
    CFG_LENGTH_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    status_t             status;
    logic [MATCH_W-1:0]  match_id;
    logic [LINE_W-1:0]   stored_count;
    logic                line_done;
  } result_t;

  typedef struct packed {
    logic clear;
    logic update;
  } lane_ctrl_t;

  // Text is right-aligned: the last character sits in the low byte.
  localparam logic [PAT_BITS-1:0] PAT_TEXT [PAT_COUNT] = '{
    PAT_BITS'("LINK IS BUILDED\015\012"),
    PAT_BITS'("no change\015\012"),
    PAT_BITS'("SEND OK\015\012"),
    PAT_BITS'("SEND FAIL\015\012"),
    PAT_BITS'("ERROR\015\012"),
    PAT_BITS'("Unlink\015\012"),
    PAT_BITS'("Linked\015\012"),
    PAT_BITS'(",CLOSED\015\012"),
    PAT_BITS'(",CONNECT\015\012"),
    PAT_BITS'("ready\015\012"),
    PAT_BITS'("+IPD,"),
    PAT_BITS'("OK\015\012"),
    PAT_BITS'("\015\012")
  };

  localparam logic [POS_W-1:0] PAT_LEN [PAT_COUNT] = '{
    5'd17, 5'd11, 5'd9, 5'd11, 5'd7, 5'd8, 5'd8, 5'd9, 5'd10, 5'd7, 5'd5, 5'd4, 5'd2
  };

endpackage

@@ hdl/mprm_in_if.sv @@
// ----------------------------------------------------------------------------
// mprm_in_if
// Request channel: request type and received byte with valid/ready.
// ----------------------------------------------------------------------------
interface mprm_in_if;
  import mprm_pkg::*;

  logic       valid;
  logic       ready;
  req_type_t  req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

@@ hdl/mprm_out_if.sv @@
// ----------------------------------------------------------------------------
// mprm_out_if
// Result channel: status, match index, line count and line flag.
// ----------------------------------------------------------------------------
interface mprm_out_if;
  import mprm_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic [MATCH_W-1:0] match_id;
  logic [LINE_W-1:0]  stored_count;
  logic               line_done;

  modport source (output valid, output status, output match_id, output stored_count,
                  output line_done, input ready);
  modport sink   (input valid, input status, input match_id, input stored_count,
                  input line_done, output ready);
endinterface

@@ hdl/mprm_pattern_lane.sv @@
// ----------------------------------------------------------------------------
// mprm_pattern_lane
// Position counter and character comparator for one reply pattern.
// ----------------------------------------------------------------------------
module mprm_pattern_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  mprm_pkg::lane_ctrl_t          ctrl,
  input  logic [7:0]                    rx_byte,
  input  logic [mprm_pkg::PAT_BITS-1:0] pat_text,
  input  logic [mprm_pkg::POS_W-1:0]    pat_len,
  output logic                          done
);
  import mprm_pkg::*;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] off_cur;
  logic [POS_W-1:0] off_first;
  logic [7:0]       char_cur;
  logic [7:0]       char_first;

  assign off_cur    = pat_len - POS_W'(1) - pos;
  assign off_first  = pat_len - POS_W'(1);
  assign char_cur   = pat_text[{off_cur, 3'b000} +: 8];
  assign char_first = pat_text[{off_first, 3'b000} +: 8];

  always_comb begin
    if (pos < pat_len && rx_byte == char_cur) begin
      pos_next = pos + POS_W'(1);
    end else if (rx_byte == char_first) begin
      pos_next = POS_W'(1);
    end else begin
      pos_next = '0;
    end
  end

  assign done = (pat_len != '0) && (pos_next >= pat_len);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      pos <= '0;
    end else if (ctrl.update) begin
      pos <= pos_next;
    end
  end
endmodule

@@ hdl/multi_pattern_response_matcher.sv @@
// ----------------------------------------------------------------------------
// multi_pattern_response_matcher
// Results are registered; one request per cycle is taken while the skid entry is empty.
// All 13 pattern lanes compare the byte in parallel; a two-entry result
// buffer takes one more request while the result side stalls.
// Reset: synchronous; read idle, counters clear, accept_mask 0, limit 512.
// ----------------------------------------------------------------------------
module multi_pattern_response_matcher (
  input  logic                            clk,
  input  logic                            rst,
  mprm_in_if.sink                         req,
  mprm_out_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [mprm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mprm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mprm_pkg::*;

  logic [MASK_W-1:0]  accept_mask;
  logic [LINE_W-1:0]  length_limit;
  logic [LINE_W-1:0]  line_count;
  logic [LINE_W-1:0]  line_count_next;
  logic               read_active;
  logic               read_active_next;
  logic               prev_was_cr;
  logic               prev_was_cr_next;

  result_t            res;
  result_t            out_reg;
  result_t            skid;
  logic               out_valid;
  logic               skid_valid;

  logic               in_fire;
  logic               out_fire;
  logic               proc_byte;
  logic               at_limit;
  logic [LINE_W-1:0]  eff_limit;
  logic [LINE_W-1:0]  cnt_inc;
  logic               hit;
  logic [MATCH_W-1:0] hit_id;
  logic [PAT_COUNT-1:0] lane_done;
  lane_ctrl_t         lane_ctrl [PAT_COUNT];

  assign req.ready = !skid_valid;
  assign in_fire   = req.valid && req.ready;
  assign out_fire  = out_valid && rsp.ready;

  assign eff_limit = (length_limit > LINE_W'(LINE_DEPTH)) ? LINE_W'(LINE_DEPTH) : length_limit;
  assign at_limit  = line_count >= eff_limit;
  assign cnt_inc   = line_count + LINE_W'(1);
  assign proc_byte = in_fire && req.req_type == REQ_BYTE && read_active &&
                     req.rx_byte != 8'd0 && !at_limit;

  for (genvar g = 0; g < PAT_COUNT; g++) begin : g_lane
    mprm_pattern_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (lane_ctrl[g]),
      .rx_byte  (req.rx_byte),
      .pat_text (PAT_TEXT[g]),
      .pat_len  (PAT_LEN[g]),
      .done     (lane_done[g])
    );
  end

  // First enabled pattern in table order wins.
  always_comb begin
    hit    = 1'b0;
    hit_id = '0;
    for (int x = PAT_COUNT - 1; x >= 0; x--) begin
      if (lane_done[x] && accept_mask[x]) begin
        hit    = 1'b1;
        hit_id = MATCH_W'(x);
      end
    end
  end

  // Lanes after the winning pattern hold their positions.
  always_comb begin
    for (int x = 0; x < PAT_COUNT; x++) begin
      lane_ctrl[x].clear  = in_fire && req.req_type == REQ_START;
      lane_ctrl[x].update = proc_byte && (!hit || MATCH_W'(x) <= hit_id);
    end
  end

  always_comb begin
    res              = '0;
    res.status       = ST_IDLE;
    res.stored_count = line_count;
    line_count_next  = line_count;
    read_active_next = read_active;
    prev_was_cr_next = prev_was_cr;
    unique case (req.req_type)
      REQ_START: begin
        res.status       = ST_RUNNING;
        res.stored_count = '0;
        line_count_next  = '0;
        prev_was_cr_next = 1'b0;
        read_active_next = 1'b1;
      end
      REQ_BYTE, REQ_TIMEOUT: begin
        priority if (!read_active) begin
          res.status = ST_IDLE;
        end else if (req.req_type == REQ_TIMEOUT || req.rx_byte == 8'd0) begin
          res.status       = ST_ENDED;
          read_active_next = 1'b0;
        end else if (at_limit) begin
          res.status       = ST_LIMIT;
          read_active_next = 1'b0;
        end else if (hit) begin
          res.status       = ST_MATCHED;
          res.match_id     = hit_id;
          res.stored_count = cnt_inc;
          line_count_next  = cnt_inc;
          read_active_next = 1'b0;
        end else if (cnt_inc >= LINE_W'(2) && prev_was_cr && req.rx_byte == CHAR_LF) begin
          res.status       = ST_RUNNING;
          res.stored_count = '0;
          res.line_done    = 1'b1;
          line_count_next  = '0;
          prev_was_cr_next = 1'b0;
        end else begin
          res.status       = ST_RUNNING;
          res.stored_count = cnt_inc;
          line_count_next  = cnt_inc;
          prev_was_cr_next = req.rx_byte == CHAR_CR;
        end
      end
      default: begin
        res.status = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_active <= 1'b0;
      line_count  <= '0;
      prev_was_cr <= 1'b0;
    end else if (in_fire) begin
      read_active <= read_active_next;
      line_count  <= line_count_next;
      prev_was_cr <= prev_was_cr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accept_mask  <= '0;
      length_limit <= LINE_W'(LINE_DEPTH);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ACCEPT_MASK:  accept_mask  <= cfg_data[MASK_W-1:0];
        CFG_LENGTH_LIMIT: length_limit <= cfg_data[LINE_W-1:0];
      endcase
    end
  end

  // Output register plus skid entry; fill the skid only while the output stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_reg <= res;
      end else begin
        skid <= res;
      end
    end else if (out_fire && skid_valid) begin
      out_reg <= skid;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_reg.status;
  assign rsp.match_id     = out_reg.match_id;
  assign rsp.stored_count = out_reg.stored_count;
  assign rsp.line_done    = out_reg.line_done;

  a_line_done_clears: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.line_done |-> rsp.status == ST_RUNNING && rsp.stored_count == '0)
    else $error("line_done without a cleared running line");

  a_match_id_only_on_match: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_MATCHED |-> rsp.match_id == '0)
    else $error("match_id set on a non-match result");

  a_read_ends_on_request: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $fell(read_active) |-> $past(in_fire))
    else $error("read ended without an accepted request");

  a_line_count_bound: assert property (@(posedge clk) disable iff (rst)
    line_count <= LINE_W'(LINE_DEPTH))
    else $error("line count beyond line depth");

endmodule
